>>> src/circular_deque_defines.svh
// ----------------------------------------------------------------------------
// circular_deque_defines
// Assertion macros used by the circular deque RTL.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// condition holds at every clock edge out of reset
`define CDQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CDQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define CDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/cdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Types and constants for the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int CDQ_SLOT_COUNT = 16;
    localparam int CDQ_ITEM_BITS  = 32;

    localparam int CAP_W       = 4;
    localparam int FUNC_W      = 3;
    localparam int PORT_ITEM_W = 32;
    localparam int CNT_W       = 4;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd15;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND    = 3'd0,
        FUNC_TAKE_HEAD = 3'd1,
        FUNC_PREPEND   = 3'd2,
        FUNC_TAKE_TAIL = 3'd3,
        FUNC_PEEK_HEAD = 3'd4,
        FUNC_PEEK_TAIL = 3'd5
    } t_func;

endpackage

>>> src/cdq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ram
// Slot storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cdq_ram #(
    parameter int DEPTH = cdq_pkg::CDQ_SLOT_COUNT,
    parameter int WIDTH = cdq_pkg::CDQ_ITEM_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/circular_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended ring queue: append/prepend/take/peek at either end, one
// operation per transaction, with occupancy status in every result.
// ----------------------------------------------------------------------------
// channel   direction  ports                         tdata fields (low bit up)
// s         in         i_s_tvalid/o_s_tready/i_s_tdata  func, item_in
// m         out        o_m_tvalid/i_m_tready/o_m_tdata  ok, item_out, count,
//                                                      free_space, is_full,
//                                                      empty_flag
// cfg       in         i_cfg_wr_en/i_cfg_wr_data        capacity
//
// One transaction per cycle unless a result stalls: pointer update and slot
// access finish in the accepting cycle; the result is registered at acceptance.
// Reset clears head and tail and sets capacity to 15; slot contents are kept.
// A stalled result holds; a new transaction is taken in the cycle it leaves.
// ----------------------------------------------------------------------------
`include "circular_deque_defines.svh"

module circular_deque #(
    parameter int SLOT_COUNT = cdq_pkg::CDQ_SLOT_COUNT,
    parameter int ITEM_BITS  = cdq_pkg::CDQ_ITEM_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // cfg
    input  logic                            i_cfg_wr_en,
    input  logic [cdq_pkg::CAP_W-1:0]       i_cfg_wr_data,  // capacity
    // s
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [cdq_pkg::IN_TDATA_W-1:0]  i_s_tdata,      // func[2:0], item_in[34:3]
    // m
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [cdq_pkg::OUT_TDATA_W-1:0] o_m_tdata       // ok[0], item_out[32:1],
                                                            // count[36:33],
                                                            // free_space[40:37],
                                                            // is_full[41], empty_flag[42]
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int LW    = (IDX_W > cdq_pkg::CAP_W) ? IDX_W : cdq_pkg::CAP_W;
    localparam int FW    = cdq_pkg::FUNC_W;
    localparam int PW    = cdq_pkg::PORT_ITEM_W;

    function automatic logic [IDX_W-1:0] ring_count(
        input logic [IDX_W-1:0] tail,
        input logic [IDX_W-1:0] head,
        input logic [IDX_W-1:0] last
    );
        logic [IDX_W-1:0] diff;
        diff = tail - head;
        if (tail >= head) begin
            ring_count = diff;
        end else begin
            ring_count = diff + last + IDX_W'(1);
        end
    endfunction

    logic [cdq_pkg::CAP_W-1:0] r_cap;
    logic [IDX_W-1:0]          r_head, n_head;
    logic [IDX_W-1:0]          r_tail, n_tail;

    logic                      r_out_valid;
    logic                      r_ok, r_rd_sel;
    logic [IDX_W-1:0]          r_cnt, r_free;
    logic                      r_full, r_empty;

    logic                      s_accept;
    cdq_pkg::t_func            c_func;
    logic [ITEM_BITS-1:0]      c_item;
    logic [LW-1:0]             c_cap_ext;
    logic [IDX_W-1:0]          c_last;
    logic [IDX_W-1:0]          c_head_up, c_head_dn, c_tail_up, c_tail_dn;
    logic                      c_empty;
    logic [IDX_W-1:0]          c_cnt, n_cnt;
    logic                      n_ok, n_rd;
    logic                      c_we;
    logic [IDX_W-1:0]          c_waddr, c_raddr;
    logic [ITEM_BITS-1:0]      c_rdata;
    logic [PW-1:0]             c_item_out;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign c_func     = cdq_pkg::t_func'(i_s_tdata[FW-1:0]);
    assign c_item     = ITEM_BITS'(i_s_tdata[FW+PW-1:FW]);

    assign c_cap_ext  = LW'(r_cap);
    assign c_last     = (c_cap_ext > LW'(SLOT_COUNT - 1)) ? IDX_W'(SLOT_COUNT - 1)
                                                          : IDX_W'(c_cap_ext);
    assign c_head_up  = (r_head == c_last) ? '0 : r_head + IDX_W'(1);
    assign c_tail_up  = (r_tail == c_last) ? '0 : r_tail + IDX_W'(1);
    assign c_head_dn  = (r_head == '0) ? c_last : r_head - IDX_W'(1);
    assign c_tail_dn  = (r_tail == '0) ? c_last : r_tail - IDX_W'(1);
    assign c_empty    = (r_head == r_tail);
    assign c_cnt      = ring_count(r_tail, r_head, c_last);

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_ok    = 1'b0;
        n_rd    = 1'b0;
        c_we    = 1'b0;
        c_waddr = r_tail;
        c_raddr = r_head;
        case (c_func)
            cdq_pkg::FUNC_APPEND: begin
                if (c_tail_up != r_head) begin
                    c_we    = 1'b1;
                    c_waddr = r_tail;
                    n_tail  = c_tail_up;
                    n_ok    = 1'b1;
                end
            end
            cdq_pkg::FUNC_TAKE_HEAD: begin
                if (!c_empty) begin
                    n_rd    = 1'b1;
                    c_raddr = r_head;
                    n_head  = c_head_up;
                    n_ok    = 1'b1;
                end
            end
            cdq_pkg::FUNC_PREPEND: begin
                if (c_head_dn != r_tail) begin
                    c_we    = 1'b1;
                    c_waddr = c_head_dn;
                    n_head  = c_head_dn;
                    n_ok    = 1'b1;
                end
            end
            cdq_pkg::FUNC_TAKE_TAIL: begin
                if (!c_empty) begin
                    n_rd    = 1'b1;
                    c_raddr = c_tail_dn;
                    n_tail  = c_tail_dn;
                    n_ok    = 1'b1;
                end
            end
            cdq_pkg::FUNC_PEEK_HEAD: begin
                if (!c_empty) begin
                    n_rd    = 1'b1;
                    c_raddr = r_head;
                    n_ok    = 1'b1;
                end
            end
            cdq_pkg::FUNC_PEEK_TAIL: begin
                if (!c_empty) begin
                    n_rd    = 1'b1;
                    c_raddr = c_tail_dn;
                    n_ok    = 1'b1;
                end
            end
            default: begin
            end
        endcase
        n_cnt = ring_count(n_tail, n_head, c_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= cdq_pkg::CAP_RESET;
            r_head <= '0;
            r_tail <= '0;
        end else if (i_cfg_wr_en) begin
            r_cap  <= i_cfg_wr_data;
            r_head <= '0;
            r_tail <= '0;
        end else if (s_accept) begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_ok        <= 1'b0;
            r_rd_sel    <= 1'b0;
        end else if (s_accept) begin
            r_out_valid <= 1'b1;
            r_ok        <= n_ok;
            r_rd_sel    <= n_rd;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cnt   <= n_cnt;
            r_free  <= c_last - n_cnt;
            r_full  <= (n_cnt == c_last);
            r_empty <= (n_cnt == '0);
        end
    end

    cdq_ram #(
        .DEPTH (SLOT_COUNT),
        .WIDTH (ITEM_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s_accept && c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_item),
        .i_re    (s_accept && n_rd),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    assign c_item_out = r_rd_sel ? PW'(c_rdata) : '0;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_empty, r_full,
                         cdq_pkg::CNT_W'(r_free), cdq_pkg::CNT_W'(r_cnt),
                         c_item_out, r_ok};

    `CDQ_ASSERT_ALWAYS(a_head_in_ring, i_clk, i_rst_n, r_head <= c_last, "head outside ring")
    `CDQ_ASSERT_ALWAYS(a_tail_in_ring, i_clk, i_rst_n, r_tail <= c_last, "tail outside ring")
    `CDQ_ASSERT_ALWAYS(a_read_needs_ok, i_clk, i_rst_n, !r_rd_sel || r_ok, "read data on failure")
    `CDQ_ASSERT_IMP(a_append_fail_full, i_clk, i_rst_n, s_accept && c_func == cdq_pkg::FUNC_APPEND && !n_ok, c_cnt == c_last, "append refused below capacity")
    `CDQ_ASSERT_NEXT(a_append_grows, i_clk, i_rst_n, s_accept && !i_cfg_wr_en && c_func == cdq_pkg::FUNC_APPEND && n_ok, c_cnt == $past(c_cnt) + IDX_W'(1), "append did not grow count")

endmodule
